/* rtl/fppt_pkg.sv */
// Package for the fee priority pending table: widths, codes and shared types.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none
package fppt_pkg;
	localparam int DefCapacity = 16;
	localparam int WordW = 32;
	localparam int CountW = 7;

	typedef enum logic [1:0] {
		ACT_ADD = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_SELECT = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_ADDED = 3'd0,
		ST_INVALID = 3'd1,
		ST_FULL = 3'd2,
		ST_REMOVED = 3'd3,
		ST_SELECTED = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef struct packed {
		logic [WordW-1:0] id;
		logic [WordW-1:0] fee;
		logic [WordW-1:0] tstamp;
		logic [WordW-1:0] payload;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item
		logic scan_init; // reset the scan pointers
		logic ins_step;  // one step of the insertion shift
		logic ins_put;   // write the new entry at the insertion point
		logic rem_step;  // one step of the compaction
		logic rem_done;  // commit the new count
		logic sel_step;  // advance the select pointer
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic ins_here;  // insertion point reached
		logic rem_end;   // compaction scanned every entry
		logic sel_last;  // current select entry is the final one
		logic sel_zero;  // nothing to select
	} dp_stat_t;
endpackage
`default_nettype wire

/* rtl/fppt_datapath.sv */
// Datapath of the fee priority pending table: entry memory, count and scan pointers.
// Depends on fppt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fppt_datapath
	import fppt_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire dp_cmd_t cmd,
	output dp_stat_t stat,
	input wire entry_t in_entry,
	input wire logic [CountW-1:0] in_max,
	output entry_t rd_entry,
	output logic [CountW-1:0] gone_count
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	entry_t mem_q [CAPACITY];
	entry_t new_q;
	entry_t rd_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rptr_q;
	logic [CW-1:0] wptr_q;
	logic [CountW-1:0] gone_q;
	logic [CountW-1:0] lim_q;
	logic ranks;
	logic [CW-1:0] sel_n;

	// Count is control state and resets to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins_put) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.rem_done) begin
			count_q <= wptr_q;
		end
	end

	// The new entry ranks before the entry held in the read register.
	assign ranks = (new_q.fee != rd_q.fee) ? (new_q.fee > rd_q.fee) : (new_q.tstamp < rd_q.tstamp);

	// Select length is the smaller of the request and the count.
	assign sel_n = (CountW'(count_q) < lim_q) ? count_q : CW'(lim_q);

	// Status flags for the controller.
	assign stat = '{
		full: (count_q >= CW'(CAPACITY)),
		ins_here: (rptr_q == '0) || !ranks,
		rem_end: (rptr_q == count_q),
		sel_last: (rptr_q + CW'(1) == sel_n),
		sel_zero: (sel_n == '0)
	};

	// Pointers, captured item and the registered memory read.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_q <= in_entry;
			lim_q <= in_max;
		end
		if (cmd.scan_init) begin
			gone_q <= '0;
			wptr_q <= '0;
		end
		if (cmd.scan_init && cmd.ins_step) begin
			rptr_q <= count_q;
		end else if (cmd.scan_init) begin
			rptr_q <= '0;
			rd_q <= mem_q[0];
		end else if (cmd.ins_step) begin
			// Shift the entry below the pointer up by one.
			if (rptr_q != '0) begin
				mem_q[rptr_q[AW-1:0]] <= rd_q;
				rptr_q <= rptr_q - CW'(1);
			end
		end else if (cmd.ins_put) begin
			mem_q[rptr_q[AW-1:0]] <= new_q;
		end else if (cmd.rem_step) begin
			if (rd_q.id == new_q.id) begin
				gone_q <= gone_q + CountW'(1);
			end else begin
				mem_q[wptr_q[AW-1:0]] <= rd_q;
				wptr_q <= wptr_q + CW'(1);
			end
			rptr_q <= rptr_q + CW'(1);
		end else if (cmd.sel_step) begin
			rptr_q <= rptr_q + CW'(1);
		end
		// The read port follows the scan pointer.
		if (cmd.ins_step && cmd.scan_init) begin
			rd_q <= mem_q[AW'(count_q - CW'(1))];
		end else if (cmd.ins_step && rptr_q > CW'(1)) begin
			rd_q <= mem_q[AW'(rptr_q - CW'(2))];
		end else if ((cmd.rem_step || cmd.sel_step) && (rptr_q + CW'(1) < CW'(CAPACITY))) begin
			rd_q <= mem_q[AW'(rptr_q + CW'(1))];
		end
	end

	assign rd_entry = rd_q;
	assign gone_count = gone_q;
endmodule
`default_nettype wire

/* rtl/fppt_ctrl.sv */
// Controller of the fee priority pending table: sequences add, remove and select.
// Depends on fppt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fppt_ctrl
	import fppt_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire logic fields_valid,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] res_status,
	output logic res_entry,
	output logic res_count,
	output logic res_last,
	output dp_cmd_t cmd,
	input wire dp_stat_t stat
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INS = 6'b000010,
		S_REM = 6'b000100,
		S_SEL = 6'b001000,
		S_OUT = 6'b010000,
		S_SOUT = 6'b100000
	} state_t;

	state_t state_q;
	logic ov_q;
	logic [2:0] st_q;
	logic ent_q, cnt_q, last_q;
	logic take;

	assign in_ready = (state_q == S_IDLE);
	assign take = in_valid && in_ready;
	assign out_valid = ov_q;
	assign res_status = st_q;
	assign res_entry = ent_q;
	assign res_count = cnt_q;
	assign res_last = last_q;

	// Commands decoded from the state and the incoming item.
	always_comb begin
		cmd = '0;
		cmd.load = take;
		if (take) begin
			case (action_t'(action))
				ACT_ADD: begin
					cmd.scan_init = 1'b1;
					cmd.ins_step = fields_valid && !stat.full;
				end
				ACT_REMOVE, ACT_SELECT: cmd.scan_init = 1'b1;
				default: ;
			endcase
		end
		case (state_q)
			S_INS: begin
				cmd.ins_step = !stat.ins_here;
				cmd.ins_put = stat.ins_here;
			end
			S_REM: begin
				cmd.rem_step = !stat.rem_end;
				cmd.rem_done = stat.rem_end;
			end
			S_SOUT: cmd.sel_step = out_ready && !stat.sel_last;
			default: ;
		endcase
	end

	// State and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			st_q <= ST_ADDED;
			ent_q <= 1'b0;
			cnt_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (take) begin
					ent_q <= 1'b0;
					cnt_q <= 1'b0;
					last_q <= 1'b1;
					case (action_t'(action))
						ACT_ADD: begin
							if (!fields_valid) begin
								st_q <= ST_INVALID;
								ov_q <= 1'b1;
								state_q <= S_OUT;
							end else if (stat.full) begin
								st_q <= ST_FULL;
								ov_q <= 1'b1;
								state_q <= S_OUT;
							end else begin
								state_q <= S_INS;
							end
						end
						ACT_REMOVE: state_q <= S_REM;
						ACT_SELECT: state_q <= S_SEL;
						default: ;
					endcase
				end
				S_INS: if (stat.ins_here) begin
					st_q <= ST_ADDED;
					ov_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_REM: if (stat.rem_end) begin
					st_q <= ST_REMOVED;
					cnt_q <= 1'b1;
					ov_q <= 1'b1;
					state_q <= S_OUT;
				end
				S_SEL: begin
					ov_q <= 1'b1;
					if (stat.sel_zero) begin
						st_q <= ST_EMPTY;
						state_q <= S_OUT;
					end else begin
						st_q <= ST_SELECTED;
						ent_q <= 1'b1;
						last_q <= stat.sel_last;
						state_q <= S_SOUT;
					end
				end
				S_OUT: if (out_ready) begin
					ov_q <= 1'b0;
					state_q <= S_IDLE;
				end
				S_SOUT: if (out_ready) begin
					if (stat.sel_last) begin
						ov_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						// Return through S_SEL so the next read lands before it is shown.
						ov_q <= 1'b0;
						state_q <= S_SEL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/fee_priority_pending_table_unit.sv */
// Top level of the fee priority pending table.
// Instantiates fppt_ctrl and fppt_datapath; depends on fppt_pkg.
//
// Usage: one input channel (in_valid/in_ready) carries an item with an action:
// add, remove by id, or select from the head. One output channel
// (out_valid/out_ready) returns results; last marks the final result of an item.
// The block takes one item at a time; in_ready is high only when it is idle.
// A rejected add (invalid or full) offers its result in the cycle after it is
// accepted. An add scans from the tail, shifting one entry per cycle, and a
// remove compacts the table one entry per cycle. A select returns up to
// select_limit entries; after each entry is taken it passes through S_SEL
// while the next read lands, so a new entry is offered only after the last
// one is taken. An empty select gives one result with the empty status.
// in_ready is high again the cycle after the final result is taken; an unused
// action gives no result and the next item can follow on the next cycle.
// Entries are scanned one per cycle; a select steps only as results are taken.
// Reset empties the table at once (the count clears; no clearing pass).
// A stalled receiver holds the current result and the block waits.
`timescale 1ns / 1ps
`default_nettype none
module fee_priority_pending_table_unit
	import fppt_pkg::*;
#(
	parameter int CAPACITY = DefCapacity
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire logic [31:0] entry_id,
	input wire logic [31:0] fee_cents,
	input wire logic [31:0] arrival_time,
	input wire logic [31:0] payload_ref,
	input wire logic fields_valid,
	input wire logic [6:0] select_limit,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] status,
	output logic [31:0] out_id,
	output logic [31:0] out_fee,
	output logic [31:0] out_time,
	output logic [31:0] out_payload,
	output logic [6:0] removed_count,
	output logic last
);
	dp_cmd_t cmd;
	dp_stat_t stat;
	entry_t in_e, rd_e;
	logic [CountW-1:0] gone;
	logic r_ent, r_cnt;

	assign in_e = '{id: entry_id, fee: fee_cents, tstamp: arrival_time, payload: payload_ref};

	fppt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .fields_valid(fields_valid), .out_valid(out_valid),
		.out_ready(out_ready), .res_status(status), .res_entry(r_ent),
		.res_count(r_cnt), .res_last(last), .cmd(cmd), .stat(stat)
	);

	fppt_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .in_entry(in_e),
		.in_max(select_limit), .rd_entry(rd_e), .gone_count(gone)
	);

	// Zero the entry fields unless a selected entry is shown.
	assign out_id = r_ent ? rd_e.id : '0;
	assign out_fee = r_ent ? rd_e.fee : '0;
	assign out_time = r_ent ? rd_e.tstamp : '0;
	assign out_payload = r_ent ? rd_e.payload : '0;
	assign removed_count = r_cnt ? gone : '0;
endmodule
`default_nettype wire

/* tb/tb_fee_priority_pending_table_unit.sv */
// Testbench for fee_priority_pending_table_unit: random and directed adds, removes and selects.
// Holds its own ordered-table predictor in a scoreboard class; depends on fppt_pkg and the RTL.
`timescale 1ns / 1ps
module tb_fee_priority_pending_table_unit
	import fppt_pkg::*;
();

	localparam int Cap = DefCapacity;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] id;
		logic [31:0] fee;
		logic [31:0] tstamp;
		logic [31:0] payload;
		logic [6:0] removed;
		logic last;
	} outcome_t;

	// Scoreboard: keeps a copy of the ordered table and the queue of pending outcomes.
	class pending_table_board;
		entry_t rows[Cap];
		int rows_used;
		outcome_t waiting[$];
		int errors;
		int outcomes_seen;

		function void push_outcome(status_t st, entry_t e, int gone, bit lst);
			outcome_t o;
			o.status = st;
			o.id = e.id;
			o.fee = e.fee;
			o.tstamp = e.tstamp;
			o.payload = e.payload;
			o.removed = gone[6:0];
			o.last = lst;
			waiting.push_back(o);
		endfunction

		// Note an accepted item and work out the outcomes it causes.
		function void note_item(action_t act, entry_t e, bit ok, int maxc);
			entry_t blank;
			int pos;
			int w;
			int gone;
			int n;
			blank = '0;
			case (act)
				ACT_ADD: begin
					if (!ok) begin
						push_outcome(ST_INVALID, blank, 0, 1'b1);
					end else if (rows_used >= Cap) begin
						push_outcome(ST_FULL, blank, 0, 1'b1);
					end else begin
						// New entry goes after every entry that does not rank below it.
						pos = rows_used;
						while (pos > 0 && (e.fee > rows[pos-1].fee ||
							(e.fee == rows[pos-1].fee && e.tstamp < rows[pos-1].tstamp)))
							pos--;
						for (int i = rows_used; i > pos; i--)
							rows[i] = rows[i-1];
						rows[pos] = e;
						rows_used++;
						push_outcome(ST_ADDED, blank, 0, 1'b1);
					end
				end
				ACT_REMOVE: begin
					w = 0;
					gone = 0;
					for (int i = 0; i < rows_used; i++) begin
						if (rows[i].id == e.id) begin
							gone++;
						end else begin
							rows[w] = rows[i];
							w++;
						end
					end
					rows_used = w;
					push_outcome(ST_REMOVED, blank, gone, 1'b1);
				end
				ACT_SELECT: begin
					n = (maxc < rows_used) ? maxc : rows_used;
					if (n == 0)
						push_outcome(ST_EMPTY, blank, 0, 1'b1);
					for (int i = 0; i < n; i++)
						push_outcome(ST_SELECTED, rows[i], 0, i + 1 == n);
				end
				default: ;
			endcase
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			outcomes_seen++;
			if (waiting.size() == 0) begin
				$error("unexpected result: status %0d", got.status);
				errors++;
				return;
			end
			want = waiting.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.id !== want.id) begin
				$error("out_id: expected %0h, got %0h", want.id, got.id);
				errors++;
			end
			if (got.fee !== want.fee) begin
				$error("out_fee: expected %0h, got %0h", want.fee, got.fee);
				errors++;
			end
			if (got.tstamp !== want.tstamp) begin
				$error("out_time: expected %0h, got %0h", want.tstamp, got.tstamp);
				errors++;
			end
			if (got.payload !== want.payload) begin
				$error("out_payload: expected %0h, got %0h", want.payload, got.payload);
				errors++;
			end
			if (got.removed !== want.removed) begin
				$error("removed_count: expected %0d, got %0d", want.removed, got.removed);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = '0;
	logic [31:0] entry_id = '0;
	logic [31:0] fee_cents = '0;
	logic [31:0] arrival_time = '0;
	logic [31:0] payload_ref = '0;
	logic fields_valid = 1'b0;
	logic [6:0] select_limit = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [2:0] status;
	logic [31:0] out_id;
	logic [31:0] out_fee;
	logic [31:0] out_time;
	logic [31:0] out_payload;
	logic [6:0] removed_count;
	logic last;

	pending_table_board board = new();
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;
	// Small pool of ids so duplicates are frequent; send_random also draws small fees and times for ties.
	logic [31:0] id_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};

	always #6 clk = ~clk;

	fee_priority_pending_table_unit dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .entry_id(entry_id), .fee_cents(fee_cents),
		.arrival_time(arrival_time), .payload_ref(payload_ref),
		.fields_valid(fields_valid), .select_limit(select_limit),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.out_id(out_id), .out_fee(out_fee), .out_time(out_time),
		.out_payload(out_payload), .removed_count(removed_count), .last(last)
	);

	// Receiver: random stalls, checks each accepted result.
	always @(posedge clk) begin
		outcome_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.status = status;
				got.id = out_id;
				got.fee = out_fee;
				got.tstamp = out_time;
				got.payload = out_payload;
				got.removed = removed_count;
				got.last = last;
				board.check_outcome(got);
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Send one item: optional idle gap, then hold valid until accepted.
	// Valid stays high after acceptance so back-to-back items need no gap.
	task automatic send_item(action_t act, logic [31:0] id, logic [31:0] fee,
		logic [31:0] ts, logic [31:0] pl, bit ok, int maxc);
		entry_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		entry_id <= id;
		fee_cents <= fee;
		arrival_time <= ts;
		payload_ref <= pl;
		fields_valid <= ok;
		select_limit <= maxc[6:0];
		do
			@(posedge clk);
		while (!in_ready);
		e.id = id;
		e.fee = fee;
		e.tstamp = ts;
		e.payload = pl;
		board.note_item(act, e, ok, maxc);
		items_sent++;
	endtask

	task automatic send_random();
		int pick;
		logic [31:0] fee;
		logic [31:0] ts;
		pick = $urandom_range(99);
		fee = ($urandom_range(1)) ? $urandom_range(3) : $urandom();
		ts = ($urandom_range(1)) ? $urandom_range(2) : $urandom();
		if (pick < 50)
			send_item(ACT_ADD, id_pool[2'($urandom_range(3))], fee, ts, $urandom(),
				$urandom_range(9) != 0, 0);
		else if (pick < 68)
			send_item(ACT_REMOVE, ($urandom_range(3) == 0) ? $urandom() :
				id_pool[2'($urandom_range(3))], $urandom(), $urandom(), $urandom(),
				1'($urandom_range(1)), $urandom_range(127));
		else if (pick < 95)
			send_item(ACT_SELECT, $urandom(), $urandom(), $urandom(), $urandom(),
				1'($urandom_range(1)), ($urandom_range(7) == 0) ? $urandom_range(127) :
				$urandom_range(Cap + 1));
		else
			send_item(ACT_NONE, $urandom(), $urandom(), $urandom(), $urandom(),
				1'($urandom_range(1)), $urandom_range(127));
	endtask

	initial begin
		send_idle_pct = 17;
		recv_idle_pct = 85;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty select, invalid add, extremes, ties, fill to full.
		send_item(ACT_SELECT, 0, 0, 0, 0, 1'b1, 5);
		send_item(ACT_REMOVE, 32'hFFFF_FFFF, 0, 0, 0, 1'b0, 0);
		send_item(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, 0);
		send_item(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 64);
		send_item(ACT_ADD, 0, 0, 0, 0, 1'b1, 0);
		send_item(ACT_ADD, 7, 5, 9, 32'hA, 1'b1, 0);
		send_item(ACT_ADD, 7, 5, 9, 32'hB, 1'b1, 0);
		send_item(ACT_ADD, 8, 5, 3, 32'hC, 1'b1, 0);
		send_item(ACT_NONE, 7, 5, 3, 1, 1'b1, 127);
		send_item(ACT_SELECT, 0, 0, 0, 0, 1'b0, 0);
		send_item(ACT_SELECT, 0, 0, 0, 0, 1'b0, 127);
		for (int i = 0; i < 12; i++)
			send_item(ACT_ADD, i, $urandom(), $urandom(), $urandom(), 1'b1, 0);
		send_item(ACT_ADD, 1, 2, 3, 4, 1'b1, 0);
		send_item(ACT_ADD, 1, 2, 3, 4, 1'b0, 0);
		send_item(ACT_SELECT, 0, 0, 0, 0, 1'b1, 64);
		send_item(ACT_REMOVE, 7, 0, 0, 0, 1'b1, 0);
		send_item(ACT_REMOVE, 12345, 0, 0, 0, 1'b1, 0);

		// Random part in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 85;
				recv_idle_pct = 17;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int i = 0; i < 131; i++)
				send_random();
		end
		in_valid <= 1'b0;

		while (board.waiting.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d items (adds, removes, selects, ignored), checked %0d results.",
			items_sent, board.outcomes_seen);
		if (board.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

/* fee_priority_pending_table_unit.f */
rtl/fppt_pkg.sv
rtl/fppt_datapath.sv
rtl/fppt_ctrl.sv
rtl/fee_priority_pending_table_unit.sv
tb/tb_fee_priority_pending_table_unit.sv
